/* rtl/glt_pkg.sv */
// Package for the G-code line tokenizer: kinds, modes, character constants,
// event-group struct and character class functions. No dependencies.
package glt_pkg;

    localparam int LETTERS_W = 26;
    localparam logic [LETTERS_W-1:0] ALLOWED_RESET = 26'd59686881;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        K_BEGIN = 2'd0,
        K_ARG   = 2'd1,
        K_END   = 2'd2,
        K_LINE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CM_NONE  = 2'd0,
        CM_PAREN = 2'd1,
        CM_REST  = 2'd2
    } t_cmode;

    typedef enum logic [2:0] {
        LX_IDLE      = 3'd0,
        LX_PEND_LET  = 3'd1,
        LX_PEND_STAR = 3'd2,
        LX_PEND_DOL  = 3'd3,
        LX_IN_LET    = 3'd4,
        LX_IN_STAR   = 3'd5,
        LX_IN_DOL    = 3'd6,
        LX_IN_REST   = 3'd7
    } t_lex;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_BRACE   = 8'h7B;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_N       = 8'h4E;
    localparam logic [7:0] CH_A       = 8'h41;

    // Up to three events per word: count plus per-slot kind and tag.
    typedef struct packed {
        logic [1:0] cnt;
        logic [2:0][1:0] kind;
        logic [2:0][7:0] tag;
        logic [7:0] data;
        logic inval;
    } t_evgrp;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return is_digit(c) || c inside {8'h2B, 8'h2D, 8'h2E};
    endfunction

    function automatic logic is_alnum_hash(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_HASH;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c inside {[8'h09:8'h0D]};
    endfunction

endpackage

/* rtl/glt_front.sv */
// Front end: accepts words, strips comments and blanks, runs the lexer and
// produces one event group per word. Depends on glt_pkg.
module glt_front import glt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [LETTERS_W-1:0] i_cfg_data,
    input  logic                 i_fire,
    input  logic [7:0]           i_byte,
    input  logic                 i_eol,
    output t_evgrp               o_grp
);

    logic [LETTERS_W-1:0] r_allowed;
    t_cmode r_cm, n_cm;
    t_lex   r_lx, n_lx;
    logic [7:0] r_tag, n_tag;
    logic r_sup, n_sup, r_inv, n_inv;
    t_evgrp g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allowed <= ALLOWED_RESET;
            r_cm <= CM_NONE;
            r_lx <= LX_IDLE;
            r_tag <= '0;
            r_sup <= 1'b0;
            r_inv <= 1'b0;
        end else begin
            if (i_cfg_we) r_allowed <= i_cfg_data;
            if (i_fire) begin
                r_cm <= n_cm;
                r_lx <= n_lx;
                r_tag <= n_tag;
                r_sup <= n_sup;
                r_inv <= n_inv;
            end
        end
    end

    always_comb begin
        logic [7:0] c;
        logic [7:0] up;
        logic do_start, em_begin, em_arg, em_end;
        logic [4:0] k;
        c = i_byte;
        up = (c >= 8'h61) ? c - 8'd32 : c;
        n_cm = r_cm;
        n_lx = r_lx;
        n_tag = r_tag;
        n_sup = r_sup;
        n_inv = r_inv;
        do_start = 1'b0;
        em_begin = 1'b0;
        em_arg = 1'b0;
        em_end = 1'b0;
        k = 5'(r_tag - CH_A);
        g = '0;
        if (i_eol) begin
            if (r_lx inside {LX_IN_LET, LX_IN_STAR, LX_IN_DOL, LX_IN_REST}) em_end = 1'b1;
            else if (r_lx inside {LX_PEND_LET, LX_PEND_STAR, LX_PEND_DOL}) n_inv = 1'b1;
        end else if (r_cm == CM_PAREN) begin
            if (c == CH_RPAREN) n_cm = CM_NONE;
        end else if (r_cm == CM_REST) begin
            n_cm = CM_REST;
        end else if (c == CH_SEMI) begin
            n_cm = CM_REST;
        end else if (c == CH_LPAREN) begin
            n_cm = CM_PAREN;
        end else if (!is_space(c)) begin
            case (r_lx)
                LX_PEND_LET: begin
                    if (is_num(c)) begin
                        if (r_tag == CH_N) n_sup = 1'b1;
                        else if (!r_allowed[k]) n_inv = 1'b1;
                        em_begin = 1'b1;
                        em_arg = 1'b1;
                        n_lx = LX_IN_LET;
                    end else begin
                        n_inv = 1'b1;
                        do_start = 1'b1;
                    end
                end
                LX_PEND_STAR: begin
                    if (is_digit(c)) begin
                        em_begin = 1'b1;
                        em_arg = 1'b1;
                        n_lx = LX_IN_STAR;
                    end else begin
                        n_inv = 1'b1;
                        do_start = 1'b1;
                    end
                end
                LX_PEND_DOL: begin
                    if (c == CH_DOLLAR) begin
                        em_begin = 1'b1;
                        em_arg = 1'b1;
                        em_end = 1'b1;
                        n_lx = LX_IDLE;
                    end else if (is_alnum_hash(c)) begin
                        em_begin = 1'b1;
                        em_arg = 1'b1;
                        n_lx = LX_IN_DOL;
                    end else begin
                        n_inv = 1'b1;
                        do_start = 1'b1;
                    end
                end
                LX_IN_LET: begin
                    if (is_num(c)) em_arg = 1'b1;
                    else begin em_end = 1'b1; do_start = 1'b1; end
                end
                LX_IN_STAR: begin
                    if (is_digit(c)) em_arg = 1'b1;
                    else begin em_end = 1'b1; do_start = 1'b1; end
                end
                LX_IN_DOL: begin
                    if (is_alnum_hash(c)) em_arg = 1'b1;
                    else begin em_end = 1'b1; do_start = 1'b1; end
                end
                LX_IN_REST: em_arg = 1'b1;
                default: do_start = 1'b1;
            endcase
        end

        // Token end precedes any new token start; emitted under the old tag.
        if (em_end && !(em_begin || em_arg)) begin
            if (!r_sup) begin
                g.kind[0] = K_END;
                g.cnt = 2'd1;
            end
            g.tag[0] = r_tag;
        end else if (em_begin || em_arg) begin
            g.tag = {3{r_tag}};
            g.data = c;
            if (!n_sup) begin
                if (em_begin) begin
                    g.kind[0] = K_BEGIN;
                    g.kind[1] = K_ARG;
                    g.kind[2] = K_END;
                    g.cnt = em_end ? 2'd3 : 2'd2;
                end else begin
                    g.kind[0] = K_ARG;
                    g.cnt = 2'd1;
                end
            end
        end
        if (em_end) begin
            n_sup = 1'b0;
            n_lx = LX_IDLE;
        end

        if (do_start) begin
            n_sup = 1'b0;
            if (c == CH_PERCENT || c == CH_BRACE) begin
                n_tag = c;
                n_lx = LX_IN_REST;
                g.tag[g.cnt] = c;
                g.kind[g.cnt] = K_BEGIN;
                g.cnt = g.cnt + 2'd1;
            end else if (c == CH_DOLLAR) begin
                n_tag = CH_DOLLAR;
                n_lx = LX_PEND_DOL;
            end else if (is_alpha(c)) begin
                n_tag = up;
                n_lx = LX_PEND_LET;
            end else if (c == CH_STAR) begin
                n_tag = CH_STAR;
                n_lx = LX_PEND_STAR;
            end else begin
                n_inv = 1'b1;
                n_lx = LX_IDLE;
            end
        end

        if (i_eol) begin
            g.kind[g.cnt] = K_LINE;
            g.inval = n_inv;
            g.cnt = g.cnt + 2'd1;
            n_cm = CM_NONE;
            n_lx = LX_IDLE;
            n_tag = '0;
            n_sup = 1'b0;
            n_inv = 1'b0;
        end
    end

    assign o_grp = g;

endmodule

/* rtl/glt_queue.sv */
// Event-group queue between the front end and the back end.
// Depends on glt_pkg.
module glt_queue import glt_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_evgrp i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_evgrp o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_evgrp r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            if (i_pop) r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    assign o_data = r_mem[r_rp];
    assign o_full = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue count out of range");

endmodule

/* rtl/glt_back.sv */
// Back end: walks each event group one event per cycle, whenever the output
// register is empty or being accepted, into that register. Depends on glt_pkg.
module glt_back import glt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_evgrp     i_grp,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_tag,
    output logic [7:0] o_data_byte,
    output logic       o_line_invalid,
    output logic       o_last
);

    logic [1:0] r_idx;
    logic r_valid;
    logic [1:0] r_kind;
    logic [7:0] r_tag, r_data;
    logic r_inv, r_last;
    logic load, have;
    logic [1:0] kd;

    assign have = !i_empty && (i_grp.cnt != 2'd0);
    assign load = (!r_valid || i_ready) && !i_empty;
    assign kd = i_grp.kind[r_idx];
    assign o_pop = load && (r_idx + 2'd1 >= i_grp.cnt || i_grp.cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx <= '0;
        end else begin
            if (load && have) begin
                r_valid <= 1'b1;
                r_idx <= o_pop ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && have) begin
            r_kind <= kd;
            r_tag <= (kd == K_LINE) ? 8'd0 : i_grp.tag[r_idx];
            r_data <= (kd == K_ARG) ? i_grp.data : 8'd0;
            r_inv <= (kd == K_LINE) ? i_grp.inval : 1'b0;
            r_last <= o_pop;
        end
    end

    assign o_valid = r_valid;
    assign o_kind = r_kind;
    assign o_tag = r_tag;
    assign o_data_byte = r_data;
    assign o_line_invalid = r_inv;
    assign o_last = r_last;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_kind)) else $error("output dropped");
    a_inv_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_inv |-> r_kind == K_LINE && r_last) else $error("bad line flag");

endmodule

/* rtl/gcode_line_tokenizer_core.sv */
// G-code line tokenizer top level: front end, event queue and back end.
// Depends on glt_pkg, glt_front, glt_queue, glt_back.
// Accepts one byte word per cycle while the event queue has room; each word
// yields zero to three output words, which the back end delivers at one per
// cycle while the receiver is ready, so the sustained rate is one byte per
// cycle for bytes that give at most one event, and less for bytes with more.
module gcode_line_tokenizer_core import glt_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [LETTERS_W-1:0] i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_byte_in,
    input  logic                 i_end_line,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_kind,
    output logic [7:0]           o_tag,
    output logic [7:0]           o_data_byte,
    output logic                 o_line_invalid,
    output logic                 o_last
);

    t_evgrp grp_in, grp_out;
    logic full, empty, pop, fire;

    assign o_ready = !full;
    assign fire = i_valid && !full;

    glt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_fire(fire), .i_byte(i_byte_in), .i_eol(i_end_line), .o_grp(grp_in)
    );

    glt_queue #(.DEPTH(DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(fire), .i_data(grp_in),
        .o_full(full), .i_pop(pop), .o_empty(empty), .o_data(grp_out)
    );

    glt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_grp(grp_out),
        .o_pop(pop), .o_valid(o_valid), .i_ready(i_ready), .o_kind(o_kind),
        .o_tag(o_tag), .o_data_byte(o_data_byte), .o_line_invalid(o_line_invalid),
        .o_last(o_last)
    );

endmodule

/* tb/tb_gcode_line_tokenizer_core.sv */
// Testbench for gcode_line_tokenizer_core: drives byte words and line ends,
// predicts token events with an in-file lexer model and checks every output word.
// Depends on glt_pkg and the RTL of the tokenizer.
module tb_gcode_line_tokenizer_core;
    import glt_pkg::*;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tag;
        logic [7:0] data;
        logic       inval;
        logic       last;
    } t_event;

    typedef struct {
        logic [7:0] b;
        logic       eol;
        logic       has_exp;
        t_event     exp0;
    } t_row;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [LETTERS_W-1:0] i_cfg_data = '0;
    logic i_valid = 0;
    logic o_ready;
    logic [7:0] i_byte_in = '0;
    logic i_end_line = 0;
    logic o_valid;
    logic i_ready = 0;
    logic [1:0] o_kind;
    logic [7:0] o_tag;
    logic [7:0] o_data_byte;
    logic o_line_invalid;
    logic o_last;

    gcode_line_tokenizer_core DUT (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [LETTERS_W-1:0] letters_mask;
    t_cmode cmode;
    t_lex   lmode;
    logic [7:0] cur_tag;
    logic   suppress, invalid;
    t_event step_events[$];
    t_event pending_events[$];

    int errors = 0;
    int words_in = 0, events_out = 0, lines_out = 0;
    int idle_pct = 36;
    int rx_hold = 0;
    int stall_cycles = 0;
    logic timed_out = 0;

    function automatic logic c_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic logic c_alpha(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction
    function automatic logic c_num(logic [7:0] c);
        return c_digit(c) || c == "+" || c == "-" || c == ".";
    endfunction
    function automatic logic c_word(logic [7:0] c);
        return c_alpha(c) || c_digit(c) || c == CH_HASH;
    endfunction
    function automatic logic c_blank(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    task automatic emit(t_kind k, logic [7:0] t, logic [7:0] d, logic inv);
        t_event e;
        e.kind = k; e.tag = t; e.data = d; e.inval = inv; e.last = 1'b0;
        if (step_events.size() < 3) step_events = {step_events, e};
    endtask

    task automatic tok_begin();
        if (!suppress) emit(K_BEGIN, cur_tag, 8'd0, 1'b0);
    endtask
    task automatic tok_arg(logic [7:0] c);
        if (!suppress) emit(K_ARG, cur_tag, c, 1'b0);
    endtask
    task automatic tok_end();
        if (!suppress) emit(K_END, cur_tag, 8'd0, 1'b0);
        suppress = 0;
        lmode = LX_IDLE;
    endtask

    task automatic tok_start(logic [7:0] c);
        suppress = 0;
        if (c == CH_PERCENT || c == CH_BRACE) begin
            cur_tag = c;
            tok_begin();
            lmode = LX_IN_REST;
        end else if (c == CH_DOLLAR) begin
            cur_tag = c;
            lmode = LX_PEND_DOL;
        end else if (c_alpha(c)) begin
            cur_tag = (c >= "a") ? c - 8'd32 : c;
            lmode = LX_PEND_LET;
        end else if (c == CH_STAR) begin
            cur_tag = c;
            lmode = LX_PEND_STAR;
        end else begin
            invalid = 1;
            lmode = LX_IDLE;
        end
    endtask

    task automatic lex_byte(logic [7:0] c);
        logic [7:0] k;
        case (lmode)
            LX_PEND_LET: begin
                if (c_num(c)) begin
                    if (cur_tag == CH_N) suppress = 1;
                    else begin
                        k = cur_tag - CH_A;
                        if (k > 25 || !letters_mask[k[4:0]]) invalid = 1;
                    end
                    tok_begin(); tok_arg(c); lmode = LX_IN_LET;
                end else begin
                    invalid = 1; tok_start(c);
                end
            end
            LX_PEND_STAR: begin
                if (c_digit(c)) begin
                    tok_begin(); tok_arg(c); lmode = LX_IN_STAR;
                end else begin
                    invalid = 1; tok_start(c);
                end
            end
            LX_PEND_DOL: begin
                if (c == CH_DOLLAR) begin
                    tok_begin(); tok_arg(c); tok_end();
                end else if (c_word(c)) begin
                    tok_begin(); tok_arg(c); lmode = LX_IN_DOL;
                end else begin
                    invalid = 1; tok_start(c);
                end
            end
            LX_IN_LET: if (c_num(c)) tok_arg(c); else begin tok_end(); tok_start(c); end
            LX_IN_STAR: if (c_digit(c)) tok_arg(c); else begin tok_end(); tok_start(c); end
            LX_IN_DOL: if (c_word(c)) tok_arg(c); else begin tok_end(); tok_start(c); end
            LX_IN_REST: tok_arg(c);
            default: tok_start(c);
        endcase
    endtask

    task automatic predict_word(logic [7:0] c, logic eol);
        step_events.delete();
        if (eol) begin
            case (lmode)
                LX_IN_LET, LX_IN_STAR, LX_IN_DOL, LX_IN_REST: tok_end();
                LX_PEND_LET, LX_PEND_STAR, LX_PEND_DOL: invalid = 1;
                default: ;
            endcase
            emit(K_LINE, 8'd0, 8'd0, invalid);
            cmode = CM_NONE; lmode = LX_IDLE; cur_tag = 0;
            suppress = 0; invalid = 0;
        end else if (cmode == CM_PAREN) begin
            if (c == CH_RPAREN) cmode = CM_NONE;
        end else if (cmode == CM_REST) begin
        end else if (c == CH_SEMI) cmode = CM_REST;
        else if (c == CH_LPAREN) cmode = CM_PAREN;
        else if (!c_blank(c)) lex_byte(c);
        if (step_events.size() > 0) step_events[step_events.size()-1].last = 1;
        pending_events = {pending_events, step_events};
    endtask

    task automatic report(string what, t_event got, t_event want);
        errors++;
        $display("MISMATCH %s: got k=%0d t=%h d=%h i=%0b l=%0b want k=%0d t=%h d=%h i=%0b l=%0b",
            what, got.kind, got.tag, got.data, got.inval, got.last,
            want.kind, want.tag, want.data, want.inval, want.last);
    endtask

    // output checker and receiver
    always @(posedge i_clk) begin
        t_event got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_kind, o_tag, o_data_byte, o_line_invalid, o_last};
            events_out++;
            if (o_kind == K_LINE) lines_out++;
            if (pending_events.size() == 0) report("unexpected word", got, '0);
            else begin
                want = pending_events.pop_front();
                if (got !== want) report("field", got, want);
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_ready <= 0;
        end else i_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 5000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send(logic [7:0] b, logic eol);
        i_byte_in <= b;
        i_end_line <= eol;
        i_valid <= 1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_word(b, eol);
        words_in++;
        @(negedge i_clk);
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 0;
        while (pending_events.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_mask(logic [LETTERS_W-1:0] m);
        drain();
        i_cfg_we <= 1; i_cfg_data <= m;
        @(negedge i_clk);
        i_cfg_we <= 0;
        letters_mask = m;
    endtask

    function automatic logic [7:0] pick_num();
        case ($urandom_range(5))
            0: return "+";
            1: return "-";
            2: return ".";
            default: return 8'("0" + $urandom_range(9));
        endcase
    endfunction

    task automatic send_line();
        int n;
        logic [7:0] c;
        n = $urandom_range(1, 6);
        repeat (n) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7: begin
                    c = 8'("A" + $urandom_range(25));
                    if ($urandom_range(1)) c = c + 8'd32;
                    send(c, 0);
                    repeat ($urandom_range(1, 4)) send(pick_num(), 0);
                end
                8: begin send(CH_DOLLAR, 0); send(CH_DOLLAR, 0); end
                9: begin
                    send(CH_DOLLAR, 0);
                    repeat ($urandom_range(0, 3))
                        send($urandom_range(1) ? CH_HASH : 8'("a" + $urandom_range(25)), 0);
                end
                10: begin
                    send(CH_STAR, 0);
                    repeat ($urandom_range(3)) send(8'("0" + $urandom_range(9)), 0);
                end
                11: begin
                    send(CH_LPAREN, 0);
                    repeat ($urandom_range(3)) send(8'($urandom_range(255)), 0);
                    if ($urandom_range(3)) send(CH_RPAREN, 0);
                end
                12: send(" ", 0);
                13: send(8'(9 + $urandom_range(4)), 0);
                14: begin send(CH_SEMI, 0); send(8'($urandom_range(255)), 0); end
                15: begin
                    send($urandom_range(1) ? CH_PERCENT : CH_BRACE, 0);
                    repeat ($urandom_range(3)) send(8'($urandom_range(255)), 0);
                end
                default: send(8'($urandom_range(255)), 0);
            endcase
        end
        send(8'($urandom_range(255)), 1);
    endtask

    t_row rows[$];
    t_event e0;

    function automatic t_row mk(logic [7:0] b, logic eol);
        t_row r;
        r.b = b; r.eol = eol; r.has_exp = 0; r.exp0 = '0;
        return r;
    endfunction
    function automatic t_row mkx(logic [7:0] b, logic eol, t_event e);
        t_row r;
        r = mk(b, eol); r.has_exp = 1; r.exp0 = e;
        return r;
    endfunction
    function automatic void add_row(t_row r);
        rows = {rows, r};
    endfunction

    initial begin
        letters_mask = ALLOWED_RESET;
        cmode = CM_NONE; lmode = LX_IDLE; cur_tag = 0; suppress = 0; invalid = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        add_row(mkx(8'hFF, 1, '{K_LINE, 8'h00, 8'h00, 1'b0, 1'b1}));
        add_row(mk(8'h00, 0));
        add_row(mkx(8'h00, 1, '{K_LINE, 8'h00, 8'h00, 1'b1, 1'b1}));
        add_row(mk("g", 0));
        add_row(mk("1", 0));
        add_row(mk(" ", 0));
        add_row(mk("2", 0));
        add_row(mk("(", 0));
        add_row(mk("x", 0));
        add_row(mk(")", 0));
        add_row(mk("n", 0));
        add_row(mk("5", 0));
        add_row(mk(CH_DOLLAR, 0));
        add_row(mk(CH_DOLLAR, 0));
        add_row(mk(CH_STAR, 0));
        add_row(mk("9", 0));
        add_row(mk(CH_DOLLAR, 0));
        add_row(mk(CH_HASH, 0));
        add_row(mk(")", 0));
        add_row(mk("Z", 0));
        add_row(mk("Q", 0));
        add_row(mk(CH_PERCENT, 0));
        add_row(mk(8'hFF, 0));
        add_row(mk(CH_SEMI, 0));
        add_row(mk("X", 1));
        foreach (rows[i]) begin
            if (rows[i].has_exp) begin
                drain();
                predict_word(rows[i].b, rows[i].eol);
                e0 = pending_events.pop_back();
                if (e0 !== rows[i].exp0) report("table", e0, rows[i].exp0);
                pending_events = {pending_events, rows[i].exp0};
                predict_undo: begin end
                words_in--;
                // predictor already advanced; replay the word on the wire only
                i_byte_in <= rows[i].b; i_end_line <= rows[i].eol; i_valid <= 1;
                @(posedge i_clk);
                while (!o_ready) @(posedge i_clk);
                words_in++;
                @(negedge i_clk);
                i_valid <= 0;
                @(negedge i_clk);
            end else send(rows[i].b, rows[i].eol);
        end

        write_mask('0);
        repeat (10) send_line();
        write_mask({LETTERS_W{1'b1}});
        repeat (10) send_line();
        write_mask(26'($urandom()));

        // hold off the receiver while the sender keeps going
        rx_hold = 60;
        repeat (6) send_line();
        drain();

        idle_pct = 0;
        repeat (8) send_line();
        idle_pct = 36;
        write_mask(ALLOWED_RESET);
        while (words_in < 430) send_line();
        drain();

        $display("Covered %0d byte words, %0d output words, %0d line ends, four letter masks.",
            words_in, events_out, lines_out);
        if (errors == 0 && pending_events.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/glt_pkg.sv
rtl/glt_front.sv
rtl/glt_queue.sv
rtl/glt_back.sv
rtl/gcode_line_tokenizer_core.sv
tb/tb_gcode_line_tokenizer_core.sv
